// File: rtl/gyro_yaw_integrator_unit_defines.svh
// Assertion macros for the gyro yaw integrator unit.
// Included by the checker file; needs nothing else.
`ifndef GYRO_YAW_INTEGRATOR_UNIT_DEFINES_SVH
`define GYRO_YAW_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GYI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GYI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gyi_pkg.sv
// Shared types, widths and constants of the gyro yaw integrator unit.
// No dependencies; used by the channel interfaces, the top level and the checker.
package gyi_pkg;

  // Field and datapath widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned YAW_W    = 44;
  localparam int unsigned RATE_W   = 28;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RANGE_W  = 2;
  localparam int unsigned DB_W     = 26;
  localparam int unsigned GAP_W    = 20;
  // raw * 2000 stays within +/-65536000, which needs 27 signed bits
  localparam int unsigned SCALED_W = 27;
  // yaw + rate * gap stays below 2^48 in magnitude
  localparam int unsigned ACC_W    = 49;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned CAL_COUNT_MAX_DEF = 1024;

  // Yaw turn limits in 1/(32768e6) degree
  localparam logic signed [ACC_W-1:0] YAW_HALF_TURN = 49'sd5898240000000;
  localparam logic signed [ACC_W-1:0] YAW_FULL_TURN = 49'sd11796480000000;
  localparam logic signed [ACC_W-1:0] YAW_NEG_HALF  = -YAW_HALF_TURN;

  // Register reset values
  localparam logic [RANGE_W-1:0] GYRO_RANGE_RST = 2'd0;
  localparam logic [DB_W-1:0]    DEADBAND_RST   = 26'd16384;
  localparam logic [GAP_W-1:0]   MAX_GAP_RST    = 20'd1000000;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_GYRO_RANGE = 2'd0;
  localparam logic [1:0] REG_DEADBAND   = 2'd1;
  localparam logic [1:0] REG_MAX_GAP    = 2'd2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INTEGRATE  = 2'd0,
    OP_CAL_SAMPLE = 2'd1,
    OP_CAL_FINISH = 2'd2,
    OP_YAW_RESET  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_ARMED    = 2'd1,
    STS_GAP_SKIP = 2'd2,
    STS_NO_CAL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_MUL,
    ST_WRAP,
    ST_DIV,
    ST_BIAS,
    ST_DONE
  } state_e;

  // raw * 250 * 2^fs_sel, built from shifts: 250 = 256 - 4 - 2
  function automatic logic signed [SCALED_W-1:0] scale_raw(
    input logic signed [RAW_W-1:0] raw,
    input logic [RANGE_W-1:0]      fs_sel
  );
    logic signed [SCALED_W-1:0] x;
    logic signed [SCALED_W-1:0] base;
    x    = SCALED_W'(raw);
    base = (x <<< 8) - (x <<< 2) - (x <<< 1);
    return base <<< fs_sel;
  endfunction

endpackage

// File: rtl/gyi_if.sv
// Valid/ready channel interfaces of the gyro yaw integrator unit:
// the sample channel and the result channel. Depends on gyi_pkg.
interface gyi_in_if import gyi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [RAW_W-1:0]    raw_rate;
  logic [TS_W-1:0]            timestamp_us;

  modport source (output valid, opcode, raw_rate, timestamp_us, input ready);
  modport sink   (input valid, opcode, raw_rate, timestamp_us, output ready);
endinterface

interface gyi_out_if import gyi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [YAW_W-1:0]    yaw;
  logic signed [RATE_W-1:0]   corrected_rate;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, yaw, corrected_rate, status, input ready);
  modport sink   (input valid, yaw, corrected_rate, status, output ready);
endinterface

// File: rtl/gyro_yaw_integrator_unit.sv
// Gyro yaw integrator unit: takes Z-axis gyro samples with microsecond timestamps
// and returns one result per transaction. Integrate transactions scale the raw
// reading by the selected full scale, subtract the calibrated bias, zero rates
// inside the deadband, multiply by the timestamp gap and add into a yaw kept
// within +/-180 degrees; calibration transactions sum scaled samples and the
// finish transaction sets the bias to sum / count. The product is formed
// by a bit-serial multiplier that consumes one gap bit per cycle and
// the bias by a restoring divider that produces one quotient bit per cycle.
// An integrate transaction that moves the yaw passes through the multiplier
// and then the wrap, which removes whole turns one at a time; a calibration
// sample, a yaw reset, an integrate that only arms the time, a skipped sample or
// a finish without samples goes straight from evaluation to the result, and a
// finish with samples passes through the divider and the bias commit. One
// transaction is in work at a time; the next one is accepted as soon as the
// previous result sits in the output register. Depends on gyi_pkg and gyi_if.
module gyro_yaw_integrator_unit
  import gyi_pkg::*;
#(
  parameter int unsigned CAL_COUNT_MAX = CAL_COUNT_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gyi_in_if.sink            in_i,
  gyi_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W  = $clog2(CAL_COUNT_MAX + 1);
  localparam int unsigned SUM_W  = SCALED_W + CNT_W;
  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0]  CAL_LIMIT = CNT_W'(CAL_COUNT_MAX);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(GAP_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);

  // Configuration registers
  logic [RANGE_W-1:0] gyro_range_q;
  logic [DB_W-1:0]    deadband_q;
  logic [GAP_W-1:0]   max_gap_q;
  logic               cfg_wr;

  // Control
  state_e state_q, state_d;
  logic   in_take;
  logic   out_load;
  logic   out_valid_q, out_valid_d;

  // Architectural state
  logic signed [YAW_W-1:0]  yaw_q, yaw_d;
  logic [TS_W-1:0]          last_time_q, last_time_d;
  logic                     armed_q, armed_d;
  logic signed [RATE_W-1:0] bias_q, bias_d;
  logic signed [SUM_W-1:0]  cal_sum_q, cal_sum_d;
  logic [CNT_W-1:0]         cal_count_q, cal_count_d;

  // Transaction in work
  opcode_e                    op_q, op_d;
  logic signed [SCALED_W-1:0] scaled_q, scaled_d;
  logic [TS_W-1:0]            ts_q, ts_d;
  logic signed [RATE_W-1:0]   rate_q, rate_d;
  logic [TS_W-1:0]            gap_q, gap_d;
  logic signed [RATE_W-1:0]   res_rate_q, res_rate_d;
  status_e                    res_status_q, res_status_d;

  // Serial multiplier and divider
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [GAP_W-1:0]        mplier_q, mplier_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [SUM_W-1:0]        div_q, div_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic                    div_neg_q, div_neg_d;

  // Result register
  logic signed [YAW_W-1:0]  out_yaw_q;
  logic signed [RATE_W-1:0] out_rate_q;
  status_e                  out_status_q;

  // Decisions shared by the next-state and datapath logic
  logic signed [RATE_W-1:0] db_pos;
  logic signed [RATE_W-1:0] db_neg;
  logic                     in_band;
  logic signed [RATE_W-1:0] rate_eff;
  logic                     gap_skip;
  logic                     cal_room;
  logic                     cal_empty;
  logic [SUM_W-1:0]         sum_mag;
  logic                     mul_last;
  logic                     div_last;
  logic                     acc_over;
  logic                     acc_under;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         rem_sub;
  logic                     rem_ge;
  logic signed [RATE_W-1:0] quo;

  // Configuration port: writes complete in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_GYRO_RANGE: prdata = APB_DW'(gyro_range_q);
      REG_DEADBAND:   prdata = APB_DW'(deadband_q);
      REG_MAX_GAP:    prdata = APB_DW'(max_gap_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_range_q <= GYRO_RANGE_RST;
      deadband_q   <= DEADBAND_RST;
      max_gap_q    <= MAX_GAP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GYRO_RANGE: gyro_range_q <= pwdata[RANGE_W-1:0];
        REG_DEADBAND:   deadband_q   <= pwdata[DB_W-1:0];
        REG_MAX_GAP:    max_gap_q    <= pwdata[GAP_W-1:0];
        default:        ;
      endcase
    end
  end

  // Evaluate conditions on the registered transaction
  assign db_pos    = signed'({2'b00, deadband_q});
  assign db_neg    = -db_pos;
  assign in_band   = (rate_q < db_pos) && (rate_q > db_neg);
  assign rate_eff  = in_band ? '0 : rate_q;
  assign gap_skip  = (gap_q == '0) || (|gap_q[TS_W-1:GAP_W]) ||
                     (gap_q[GAP_W-1:0] > max_gap_q);
  assign cal_room  = cal_count_q < CAL_LIMIT;
  assign cal_empty = cal_count_q == '0;
  assign sum_mag   = cal_sum_q[SUM_W-1] ? SUM_W'(-cal_sum_q) : SUM_W'(cal_sum_q);
  assign mul_last  = step_q == MUL_LAST;
  assign div_last  = step_q == DIV_LAST;
  assign acc_over  = acc_q > YAW_HALF_TURN;
  assign acc_under = acc_q < YAW_NEG_HALF;

  // One restoring division step
  assign rem_sh  = {rem_q, div_q[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, cal_count_q};
  assign rem_sub = rem_sh - {1'b0, cal_count_q};
  assign quo     = signed'(div_q[RATE_W-1:0]);

  // Handshake decode from state
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    in_take     = in_i.valid && (state_q == ST_IDLE);
    out_load    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_take) state_d = ST_PREP;
      ST_PREP: state_d = ST_EVAL;
      ST_EVAL: begin
        case (op_q)
          OP_INTEGRATE:  state_d = (!armed_q || gap_skip) ? ST_DONE : ST_MUL;
          OP_CAL_FINISH: state_d = cal_empty ? ST_DONE : ST_DIV;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_MUL:  if (mul_last) state_d = ST_WRAP;
      ST_WRAP: if (!acc_over && !acc_under) state_d = ST_DONE;
      ST_DIV:  if (div_last) state_d = ST_BIAS;
      ST_BIAS: state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    yaw_d        = yaw_q;
    last_time_d  = last_time_q;
    armed_d      = armed_q;
    bias_d       = bias_q;
    cal_sum_d    = cal_sum_q;
    cal_count_d  = cal_count_q;
    op_d         = op_q;
    scaled_d     = scaled_q;
    ts_d         = ts_q;
    rate_d       = rate_q;
    gap_d        = gap_q;
    res_rate_d   = res_rate_q;
    res_status_d = res_status_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    step_d       = step_q;
    div_d        = div_q;
    rem_d        = rem_q;
    div_neg_d    = div_neg_q;

    case (state_q)
      // Capture the transaction and scale the raw reading
      ST_IDLE: begin
        if (in_take) begin
          op_d     = opcode_e'(in_i.opcode);
          scaled_d = scale_raw(in_i.raw_rate, gyro_range_q);
          ts_d     = in_i.timestamp_us;
        end
      end

      // Remove the bias and form the timestamp gap
      ST_PREP: begin
        rate_d = RATE_W'(scaled_q) - bias_q;
        gap_d  = ts_q - last_time_q;
      end

      // Act on the opcode
      ST_EVAL: begin
        res_rate_d   = '0;
        res_status_d = STS_OK;
        case (op_q)
          OP_INTEGRATE: begin
            res_rate_d  = rate_eff;
            last_time_d = ts_q;
            if (!armed_q) begin
              armed_d      = 1'b1;
              res_status_d = STS_ARMED;
            end else if (gap_skip) begin
              res_status_d = STS_GAP_SKIP;
            end else begin
              acc_d    = ACC_W'(yaw_q);
              mcand_d  = ACC_W'(rate_eff);
              mplier_d = gap_q[GAP_W-1:0];
              step_d   = '0;
            end
          end
          OP_CAL_SAMPLE: begin
            if (cal_room) begin
              cal_sum_d   = cal_sum_q + SUM_W'(scaled_q);
              cal_count_d = cal_count_q + CNT_W'(1);
            end
          end
          OP_CAL_FINISH: begin
            if (cal_empty) begin
              bias_d       = '0;
              res_status_d = STS_NO_CAL;
            end else begin
              div_d     = sum_mag;
              div_neg_d = cal_sum_q[SUM_W-1];
              rem_d     = '0;
              step_d    = '0;
            end
          end
          default: begin
            yaw_d   = '0;
            armed_d = 1'b0;
          end
        endcase
      end

      // Add one shifted partial product per gap bit
      ST_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q + STEP_W'(1);
      end

      // Remove whole turns until the yaw lies within +/-180 degrees
      ST_WRAP: begin
        if (acc_over) begin
          acc_d = acc_q - YAW_FULL_TURN;
        end else if (acc_under) begin
          acc_d = acc_q + YAW_FULL_TURN;
        end else begin
          yaw_d = signed'(acc_q[YAW_W-1:0]);
        end
      end

      // Shift in one dividend bit and produce one quotient bit
      ST_DIV: begin
        rem_d  = rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        div_d  = {div_q[SUM_W-2:0], rem_ge};
        step_d = step_q + STEP_W'(1);
      end

      // Commit the bias, restart integration and calibration
      ST_BIAS: begin
        bias_d      = div_neg_q ? -quo : quo;
        yaw_d       = '0;
        armed_d     = 1'b0;
        cal_sum_d   = '0;
        cal_count_d = '0;
      end

      default: ;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      last_time_q <= '0;
      armed_q     <= 1'b0;
      bias_q      <= '0;
      cal_sum_q   <= '0;
      cal_count_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      yaw_q       <= yaw_d;
      last_time_q <= last_time_d;
      armed_q     <= armed_d;
      bias_q      <= bias_d;
      cal_sum_q   <= cal_sum_d;
      cal_count_q <= cal_count_d;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    scaled_q     <= scaled_d;
    ts_q         <= ts_d;
    rate_q       <= rate_d;
    gap_q        <= gap_d;
    res_rate_q   <= res_rate_d;
    res_status_q <= res_status_d;
    acc_q        <= acc_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    step_q       <= step_d;
    div_q        <= div_d;
    rem_q        <= rem_d;
    div_neg_q    <= div_neg_d;
    if (out_load) begin
      out_yaw_q    <= yaw_q;
      out_rate_q   <= res_rate_q;
      out_status_q <= res_status_q;
    end
  end

  // Result channel
  assign out_o.valid          = out_valid_q;
  assign out_o.yaw            = out_yaw_q;
  assign out_o.corrected_rate = out_rate_q;
  assign out_o.status         = out_status_q;

endmodule

// File: rtl/gyi_checker.sv
// Port-level checker for the gyro yaw integrator unit and its bind.
// Depends on gyi_pkg and gyro_yaw_integrator_unit_defines.svh.
`include "gyro_yaw_integrator_unit_defines.svh"

module gyi_checker
  import gyi_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [YAW_W-1:0]  out_yaw_i,
  input logic signed [RATE_W-1:0] out_rate_i,
  input logic [STATUS_W-1:0]      out_status_i
);

  logic                    in_acc;
  logic                    out_acc;
  logic [1:0]              pend_q;
  logic signed [YAW_W-1:0] last_yaw_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track transactions in flight and the yaw of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_yaw_q <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_q <= pend_q + 2'd1;
      end else if (!in_acc && out_acc) begin
        pend_q <= pend_q - 2'd1;
      end
      if (out_acc) last_yaw_q <= out_yaw_i;
    end
  end

  `GYI_ASSERT_IMP(a_no_phantom_result, clk_i, rst_ni, out_valid_i, pend_q != 2'd0, "result without a pending transaction")
  `GYI_ASSERT_IMP(a_accept_capacity, clk_i, rst_ni, in_acc, pend_q <= 2'd1, "transaction accepted while one is still in work")
  `GYI_ASSERT_IMP(a_yaw_kept, clk_i, rst_ni, out_acc && (out_status_i == STS_ARMED || out_status_i == STS_GAP_SKIP || out_status_i == STS_NO_CAL), out_yaw_i == last_yaw_q, "yaw changed on a result that must keep it")
  `GYI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_yaw_i) && $stable(out_rate_i) && $stable(out_status_i), "stalled result changed")

endmodule

bind gyro_yaw_integrator_unit gyi_checker u_gyi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_yaw_i   (out_o.yaw),
  .out_rate_i  (out_o.corrected_rate),
  .out_status_i(out_o.status)
);
